>>> hdl/lab_pkg.sv
package lab_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int LOG_LEVELS = 10;

	// field widths fixed by the interface
	localparam int ID_W = 10;
	localparam int ST_W = 2;
	localparam int AC_W = 2;

	localparam int NODE_AW   = $clog2(MAX_NODES);
	localparam int NODE_DW   = ID_W + 1;
	localparam int TBL_DEPTH = MAX_NODES * LOG_LEVELS;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int LVL_W     = $clog2(LOG_LEVELS);
	localparam int CNT_W     = $clog2(LOG_LEVELS + 1);

	localparam logic [ID_W-1:0] DEPTH_MAX = '1;

	localparam logic [AC_W-1:0] ACT_ADD    = 2'd0;
	localparam logic [AC_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [AC_W-1:0] ACT_QUERY  = 2'd2;
	localparam logic [AC_W-1:0] ACT_NOP    = 2'd3;

	localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
	localparam logic [ST_W-1:0] STAT_ABSENT   = 2'd1;
	localparam logic [ST_W-1:0] STAT_PRESENT  = 2'd2;
	localparam logic [ST_W-1:0] STAT_NOPARENT = 2'd3;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_NODE,
		S_PARENT,
		S_LIFT,
		S_LIFT_DATA,
		S_ZERO,
		S_WALK,
		S_WALK_DATA
	} fsm_t;

	typedef struct packed {
		logic               we;
		logic [NODE_AW-1:0] waddr;
		logic [NODE_DW-1:0] wdata;
		logic [NODE_AW-1:0] raddr;
	} node_req_t;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		logic [ID_W-1:0]   wdata;
		logic [TBL_AW-1:0] raddr;
	} tbl_req_t;

endpackage

>>> hdl/lab_ram.sv
module lab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/lab_ctrl.sv
module lab_ctrl import lab_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [AC_W-1:0]    action,
	input  logic [ID_W-1:0]    node_id,
	input  logic [ID_W-1:0]    parent_id,
	input  logic [ID_W-1:0]    target_level,
	input  logic [ID_W-1:0]    root_node,
	output node_req_t          nd_req,
	input  logic [NODE_DW-1:0] nd_rdata,
	output tbl_req_t           tb_req,
	input  logic [ID_W-1:0]    tb_rdata,
	output logic               done,
	output logic [ST_W-1:0]    status,
	output logic [ID_W-1:0]    ancestor_id
);

	function automatic logic [NODE_AW-1:0] node_addr(input logic [ID_W-1:0] id);
		logic [31:0] a;
		a = 32'(id);
		return a[NODE_AW-1:0];
	endfunction

	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] j);
		logic [31:0] a;
		a = 32'(id) * 32'(LOG_LEVELS) + 32'(j);
		return a[TBL_AW-1:0];
	endfunction

	fsm_t state_q, state_d;

	logic [NODE_AW-1:0]    clr_q;
	logic [AC_W-1:0]       act_q;
	logic [ID_W-1:0]       x_q, p_q, lvl_q;
	logic [ID_W-1:0]       cur_q, cur_d;
	logic [CNT_W-1:0]      j_q, j_d;
	logic [LOG_LEVELS-1:0] k_q, k_d;
	logic                  done_q;
	logic [ST_W-1:0]       status_q;
	logic [ID_W-1:0]       anc_q;

	logic            fin;
	logic [ST_W-1:0] fin_status;
	logic [ID_W-1:0] fin_anc;

	logic            x_valid, p_valid, present, is_root, lvl_ge, too_far;
	logic            clr_last, lift_stop, lift_full, zero_last, walk_end, walk_take;
	logic [ID_W-1:0] depth, depth_inc;
	logic [31:0]     diff;
	logic [CNT_W-1:0] j_inc;

	assign present   = nd_rdata[ID_W];
	assign depth     = nd_rdata[ID_W-1:0];
	assign depth_inc = (depth == DEPTH_MAX) ? DEPTH_MAX : depth + ID_W'(1);
	assign x_valid   = (x_q != '0) && (32'(x_q) < MAX_NODES);
	assign p_valid   = (p_q != '0) && (32'(p_q) < MAX_NODES);
	assign is_root   = (x_q == root_node);
	assign lvl_ge    = (lvl_q >= depth);
	assign diff      = 32'(depth) - 32'(lvl_q);
	assign too_far   = (diff >= (32'd1 << LOG_LEVELS));
	assign clr_last  = (clr_q == NODE_AW'(MAX_NODES - 1));
	assign j_inc     = j_q + CNT_W'(1);
	assign lift_full = (32'(j_q) + 32'd1 >= LOG_LEVELS);
	assign lift_stop = lift_full || (cur_q == '0);
	assign zero_last = (32'(j_q) == LOG_LEVELS - 1);
	assign walk_end  = (j_q == CNT_W'(LOG_LEVELS));
	// a walk that reached the null node stays there without touching row zero
	assign walk_take = k_q[j_q[LVL_W-1:0]] && (cur_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_d = S_NODE;
			end
			S_NODE: begin
				state_d = S_IDLE;
				if (x_valid) begin
					unique case (act_q)
						ACT_ADD: begin
							if (!present && is_root) state_d = S_ZERO;
							else if (!present && p_valid) state_d = S_PARENT;
						end
						ACT_REMOVE: begin
							if (present) state_d = S_ZERO;
						end
						ACT_QUERY: begin
							if (present && !lvl_ge && !too_far) state_d = S_WALK;
						end
						ACT_NOP: state_d = S_IDLE;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_PARENT: state_d = present ? S_LIFT : S_IDLE;
			S_LIFT: begin
				if (!lift_stop) state_d = S_LIFT_DATA;
				else if (lift_full) state_d = S_IDLE;
				else state_d = S_ZERO;
			end
			S_LIFT_DATA: state_d = S_LIFT;
			S_ZERO: begin
				if (zero_last) state_d = S_IDLE;
			end
			S_WALK: begin
				if (walk_end) state_d = S_IDLE;
				else if (walk_take) state_d = S_WALK_DATA;
			end
			S_WALK_DATA: state_d = S_WALK;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		nd_req       = '0;
		nd_req.raddr = node_addr(node_id);
		tb_req       = '0;
		fin          = 1'b0;
		fin_status   = STAT_OK;
		fin_anc      = '0;
		cur_d        = cur_q;
		j_d          = j_q;
		k_d          = k_q;
		unique case (state_q)
			S_CLEAR: begin
				nd_req.we    = 1'b1;
				nd_req.waddr = clr_q;
				j_d          = '0;
			end
			S_IDLE: ;
			S_NODE: begin
				nd_req.raddr = node_addr(p_q);
				nd_req.waddr = node_addr(x_q);
				j_d          = '0;
				if (!x_valid) begin
					fin        = (act_q != ACT_NOP);
					fin_status = (act_q == ACT_NOP) ? STAT_OK : STAT_ABSENT;
					if (act_q == ACT_NOP) fin = 1'b1;
				end else begin
					unique case (act_q)
						ACT_ADD: begin
							if (present) begin
								fin        = 1'b1;
								fin_status = STAT_PRESENT;
							end else if (is_root) begin
								nd_req.we    = 1'b1;
								nd_req.wdata = {1'b1, ID_W'(0)};
							end else if (!p_valid) begin
								fin        = 1'b1;
								fin_status = STAT_NOPARENT;
							end
						end
						ACT_REMOVE: begin
							if (present) begin
								nd_req.we    = 1'b1;
								nd_req.wdata = {1'b0, depth};
							end else begin
								fin        = 1'b1;
								fin_status = STAT_ABSENT;
							end
						end
						ACT_QUERY: begin
							cur_d = x_q;
							k_d   = diff[LOG_LEVELS-1:0];
							if (!present) begin
								fin        = 1'b1;
								fin_status = STAT_ABSENT;
							end else if (lvl_ge) begin
								fin     = 1'b1;
								fin_anc = x_q;
							end else if (too_far) begin
								fin = 1'b1;
							end
						end
						ACT_NOP: fin = 1'b1;
						default: fin = 1'b1;
					endcase
				end
			end
			S_PARENT: begin
				if (present) begin
					nd_req.we    = 1'b1;
					nd_req.waddr = node_addr(x_q);
					nd_req.wdata = {1'b1, depth_inc};
					tb_req.we    = 1'b1;
					tb_req.waddr = tbl_addr(x_q, '0);
					tb_req.wdata = p_q;
					cur_d        = p_q;
					j_d          = '0;
				end else begin
					fin        = 1'b1;
					fin_status = STAT_NOPARENT;
				end
			end
			S_LIFT: begin
				tb_req.raddr = tbl_addr(cur_q, j_q);
				if (lift_stop) begin
					j_d = j_inc;
					fin = lift_full;
				end
			end
			S_LIFT_DATA: begin
				// the 2^(j+1)-th ancestor is the 2^j-th ancestor of the 2^j-th one
				tb_req.we    = 1'b1;
				tb_req.waddr = tbl_addr(x_q, j_inc);
				tb_req.wdata = tb_rdata;
				cur_d        = tb_rdata;
				j_d          = j_inc;
			end
			S_ZERO: begin
				tb_req.we    = 1'b1;
				tb_req.waddr = tbl_addr(x_q, j_q);
				j_d          = j_inc;
				fin          = zero_last;
			end
			S_WALK: begin
				tb_req.raddr = tbl_addr(cur_q, j_q);
				if (walk_end) begin
					fin     = 1'b1;
					fin_anc = cur_q;
				end else if (!walk_take) begin
					j_d = j_inc;
				end
			end
			S_WALK_DATA: begin
				cur_d = tb_rdata;
				j_d   = j_inc;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + NODE_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q <= action;
			x_q   <= node_id;
			p_q   <= parent_id;
			lvl_q <= target_level;
		end
		cur_q <= cur_d;
		j_q   <= j_d;
		k_q   <= k_d;
		if (fin) begin
			status_q <= fin_status;
			anc_q    <= fin_anc;
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign ancestor_id = anc_q;

`ifndef SYNTH
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) != S_IDLE && $past(state_q) != S_CLEAR))
		else $error("result strobe without an item in flight");

	a_walk_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_WALK_DATA) |-> (!tb_req.we && !nd_req.we))
		else $error("memory write during a query walk");

	a_present_only_add: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_PRESENT) |-> (act_q == ACT_ADD))
		else $error("already-present status from a non-add transfer");

	a_anc_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && anc_q != '0) |-> (act_q == ACT_QUERY && status_q == STAT_OK))
		else $error("nonzero ancestor outside a good query");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_CLEAR) |-> (32'(j_q) <= LOG_LEVELS))
		else $error("level counter out of range");
`endif

endmodule

>>> hdl/level_ancestor_binary_lifting_unit.sv
// one item at a time: each start transfer ends in a single done pulse;
// add and query take at most one ancestor-table read per level
// start is taken again in the cycle in which done shows; the receiver cannot stall
// after reset a pass clears all MAX_NODES node memory entries with busy high
// root_node resets to 1; done is high for one cycle, results hold until the next one
module level_ancestor_binary_lifting_unit import lab_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [AC_W-1:0] action,
	input  logic [ID_W-1:0] node_id,
	input  logic [ID_W-1:0] parent_id,
	input  logic [ID_W-1:0] target_level,
	input  logic            cfg_we,
	input  logic [ID_W-1:0] cfg_data,
	output logic            done,
	output logic [ST_W-1:0] status,
	output logic [ID_W-1:0] ancestor_id
);

	logic [ID_W-1:0]    root_q;
	node_req_t          nd_req;
	tbl_req_t           tb_req;
	logic [NODE_DW-1:0] nd_rdata;
	logic [ID_W-1:0]    tb_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= ID_W'(1);
		end else if (cfg_we) begin
			root_q <= cfg_data;
		end
	end

	lab_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.node_id      (node_id),
		.parent_id    (parent_id),
		.target_level (target_level),
		.root_node    (root_q),
		.nd_req       (nd_req),
		.nd_rdata     (nd_rdata),
		.tb_req       (tb_req),
		.tb_rdata     (tb_rdata),
		.done         (done),
		.status       (status),
		.ancestor_id  (ancestor_id)
	);

	// presence flag and depth per node
	lab_ram #(
		.WIDTH (NODE_DW),
		.DEPTH (MAX_NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (nd_req.we),
		.waddr (nd_req.waddr),
		.wdata (nd_req.wdata),
		.raddr (nd_req.raddr),
		.rdata (nd_rdata)
	);

	// ancestor rows, LOG_LEVELS entries per node
	lab_ram #(
		.WIDTH (ID_W),
		.DEPTH (TBL_DEPTH)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tb_req.we),
		.waddr (tb_req.waddr),
		.wdata (tb_req.wdata),
		.raddr (tb_req.raddr),
		.rdata (tb_rdata)
	);

endmodule
